// ----- hw/rtl/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
// Depends on nothing; every other file uses it by scoped names.
package spq_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int TAG_BITS_DEF      = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 3;
  // only the high op bit is decoded for clear, so code three clears as well
  localparam int OP_CLR_BIT  = 1;

  typedef enum logic [OP_BITS-1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_CLR = 2'd2
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_ENQUEUED = 3'd0,
    ST_DEQUEUED = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // sorted insert of the new entry
    logic del;  // shift toward the head, dropping cell 0
  } spq_ctrl_t;

endpackage

// ----- hw/rtl/spq_if.sv -----
// Valid/ready channel interfaces for the queue's command and result words.
// Depends on spq_pkg for field widths.
interface spq_in_if #(
  parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::OP_BITS-1:0]  op;
  logic [TAG_BITS-1:0]          entry_tag;
  logic [PRIORITY_BITS-1:0]     entry_priority;

  modport source (output valid, op, entry_tag, entry_priority, input ready);
  modport sink   (input valid, op, entry_tag, entry_priority, output ready);
endinterface

interface spq_out_if #(
  parameter int TAG_BITS   = spq_pkg::TAG_BITS_DEF,
  parameter int COUNT_BITS = $clog2(spq_pkg::DEPTH_DEF + 1)
);
  logic                            valid;
  logic                            ready;
  logic [spq_pkg::STATUS_BITS-1:0] status;
  logic [TAG_BITS-1:0]             head_tag;
  logic [COUNT_BITS-1:0]           fill_count;

  modport source (output valid, status, head_tag, fill_count, input ready);
  modport sink   (input valid, status, head_tag, fill_count, output ready);
endinterface

// ----- hw/rtl/stable_priority_queue_core.sv -----
// Stable sorted-insertion priority queue, top level.
// Depends on spq_pkg, spq_if and spq_chain.
//
// Usage:
//   in_ch carries one command word per handshake: op (enqueue, dequeue,
//   clear), entry_tag and entry_priority. out_ch returns exactly one result
//   word per command: status, head_tag and fill_count after the command.
//   Entries are held sorted by priority in a row of DEPTH cells; a new entry
//   lands after every entry of equal or lower priority, so ties leave in
//   arrival order. Every cell compares and shifts in the same cycle.
//   Latency: the result word is valid the cycle after the command is taken.
//   Throughput: one command per cycle while out_ch is being drained; the
//   single compare-and-shift step across the cell row sets that figure.
//   When out_ch stalls, the held result stays put and in_ch.ready drops
//   until it is taken, so one command at most waits inside.
//   Reset: rst_n (synchronous, active low) empties the queue and drops
//   out_ch.valid; slot contents are not cleared and need not be.
module stable_priority_queue_core #(
  parameter int DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  logic [COUNT_BITS-1:0]   count_r, count_nxt;
  logic                    out_valid_r;
  spq_pkg::status_t        status_r, status_nxt;
  logic [TAG_BITS-1:0]     head_r, head_nxt;
  logic [COUNT_BITS-1:0]   fill_r;

  logic                    fire;
  logic                    is_clr, is_enq;
  logic                    full, empty;
  spq_pkg::spq_ctrl_t      ctrl;
  logic [TAG_BITS-1:0]     chain_head;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  assign is_clr = in_ch.op[spq_pkg::OP_CLR_BIT];
  assign is_enq = in_ch.op == spq_pkg::OP_ENQ;
  assign full   = count_r == COUNT_BITS'(DEPTH);
  assign empty  = count_r == '0;

  assign ctrl.ins = fire && !is_clr && is_enq && !full;
  assign ctrl.del = fire && !is_clr && !is_enq && !empty;

  spq_chain #(
    .DEPTH         (DEPTH),
    .TAG_BITS      (TAG_BITS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .count    (count_r),
    .new_tag  (in_ch.entry_tag),
    .new_prio (in_ch.entry_priority),
    .head_tag (chain_head)
  );

  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_CLEARED;
    head_nxt   = '0;
    priority if (is_clr) begin
      count_nxt  = '0;
      status_nxt = spq_pkg::ST_CLEARED;
    end else if (is_enq) begin
      if (full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else begin
        count_nxt  = count_r + COUNT_BITS'(1);
        status_nxt = spq_pkg::ST_ENQUEUED;
      end
    end else if (empty) begin
      status_nxt = spq_pkg::ST_EMPTY;
    end else begin
      count_nxt  = count_r - COUNT_BITS'(1);
      status_nxt = spq_pkg::ST_DEQUEUED;
      head_nxt   = chain_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r <= count_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      head_r   <= head_nxt;
      fill_r   <= count_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.head_tag   = head_r;
  assign out_ch.fill_count = fill_r;

endmodule

// ----- hw/rtl/spq_cell.sv -----
// One queue slot: holds a tag and priority, compares against the new entry
// and takes its next value from itself, the new entry or a neighbor. Uses spq_pkg.
module spq_cell #(
  parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                      clk,
  input  spq_pkg::spq_ctrl_t        ctrl,
  input  logic                      occ,
  input  logic                      left_le,
  input  logic [TAG_BITS-1:0]       new_tag,
  input  logic [PRIORITY_BITS-1:0]  new_prio,
  input  logic [TAG_BITS-1:0]       left_tag,
  input  logic [PRIORITY_BITS-1:0]  left_prio,
  input  logic [TAG_BITS-1:0]       right_tag,
  input  logic [PRIORITY_BITS-1:0]  right_prio,
  output logic                      le,
  output logic [TAG_BITS-1:0]       tag,
  output logic [PRIORITY_BITS-1:0]  prio
);

  logic [TAG_BITS-1:0]      tag_r, tag_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  // entries at or below the new priority stay put, which keeps ties in order
  assign le = occ && (prio_r <= new_prio);

  always_comb begin
    tag_nxt  = tag_r;
    prio_nxt = prio_r;
    priority if (ctrl.ins) begin
      if (!le) begin
        if (left_le) begin
          tag_nxt  = new_tag;
          prio_nxt = new_prio;
        end else begin
          tag_nxt  = left_tag;
          prio_nxt = left_prio;
        end
      end
    end else if (ctrl.del) begin
      tag_nxt  = right_tag;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

  assign tag  = tag_r;
  assign prio = prio_r;

endmodule

// ----- hw/rtl/spq_chain.sv -----
// Row of DEPTH slot cells wired to their neighbors; cell 0 is the head.
// Depends on spq_pkg and spq_cell.
module spq_chain #(
  parameter int DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int COUNT_BITS    = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  spq_pkg::spq_ctrl_t        ctrl,
  input  logic [COUNT_BITS-1:0]     count,
  input  logic [TAG_BITS-1:0]       new_tag,
  input  logic [PRIORITY_BITS-1:0]  new_prio,
  output logic [TAG_BITS-1:0]       head_tag
);

  logic [TAG_BITS-1:0]      tags  [DEPTH];
  logic [PRIORITY_BITS-1:0] prios [DEPTH];
  logic                     les   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     occ;
    logic                     left_le;
    logic [TAG_BITS-1:0]      left_tag, right_tag;
    logic [PRIORITY_BITS-1:0] left_prio, right_prio;

    assign occ = COUNT_BITS'(i) < count;

    if (i == 0) begin : g_head
      assign left_le   = 1'b1;
      assign left_tag  = new_tag;
      assign left_prio = new_prio;
    end else begin : g_body
      assign left_le   = les[i-1];
      assign left_tag  = tags[i-1];
      assign left_prio = prios[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_tag  = tags[i];
      assign right_prio = prios[i];
    end else begin : g_mid
      assign right_tag  = tags[i+1];
      assign right_prio = prios[i+1];
    end

    spq_cell #(
      .TAG_BITS      (TAG_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ),
      .left_le    (left_le),
      .new_tag    (new_tag),
      .new_prio   (new_prio),
      .left_tag   (left_tag),
      .left_prio  (left_prio),
      .right_tag  (right_tag),
      .right_prio (right_prio),
      .le         (les[i]),
      .tag        (tags[i]),
      .prio       (prios[i])
    );
  end

  assign head_tag = tags[0];

endmodule

// ----- tb/tb_stable_priority_queue_core.sv -----
// Self-checking bench for stable_priority_queue_core: random and directed command
// words, a sorted-queue predictor and an in-order result scoreboard.
// Depends on spq_pkg, spq_if and the core RTL.
`timescale 1ns / 100ps

module tb_stable_priority_queue_core;

  localparam int TAG_W   = spq_pkg::TAG_BITS_DEF;
  localparam int PRIO_W  = spq_pkg::PRIORITY_BITS_DEF;
  localparam int COUNT_W = $clog2(spq_pkg::DEPTH_DEF + 1);
  localparam int OPW     = spq_pkg::OP_BITS;
  localparam int DEPTH_N = spq_pkg::DEPTH_DEF;

  localparam int RANDOM_BURSTS = 45;
  localparam int BURST_LEN     = 40;
  localparam int HOLD_CYCLES   = 120;
  localparam int HOLD_SPACING  = 700;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 200000;

  // unused encoding; the core decodes only the high bit, so it clears too
  localparam logic [OPW-1:0] OP_CLR_ALIAS = spq_pkg::OP_CLR | spq_pkg::OP_DEQ;

  typedef struct packed {
    logic [OPW-1:0]     op;
    logic [TAG_W-1:0]   tag;
    logic [PRIO_W-1:0]  prio;
  } command_t;

  typedef struct packed {
    spq_pkg::status_t   status;
    logic [TAG_W-1:0]   head_tag;
    logic [COUNT_W-1:0] fill;
  } result_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  stable_priority_queue_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  command_t command_backlog[$];
  result_t  pending_results[$];

  // mirror of the sorted queue contents, head at index 0
  logic [TAG_W-1:0]  mirror_tags [DEPTH_N];
  logic [PRIO_W-1:0] mirror_prio [DEPTH_N];
  int                mirror_fill = 0;

  int errors      = 0;
  int n_sent      = 0;
  int n_results   = 0;
  int hold_left   = 0;
  int n_holds     = 0;
  int cycle_count = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Applies one command to the mirror and returns the word the core must give back.
  function automatic result_t serve_command(logic [OPW-1:0] op, logic [TAG_W-1:0] tag,
                                            logic [PRIO_W-1:0] prio);
    result_t r;
    int      pos;
    r.head_tag = '0;
    if (op[spq_pkg::OP_CLR_BIT]) begin
      mirror_fill = 0;
      r.status    = spq_pkg::ST_CLEARED;
    end else if (op == spq_pkg::OP_ENQ) begin
      if (mirror_fill >= DEPTH_N) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        // ties go behind existing entries of the same priority
        while (pos < mirror_fill && mirror_prio[pos] <= prio) pos++;
        for (int k = mirror_fill; k > pos; k--) begin
          mirror_tags[k] = mirror_tags[k-1];
          mirror_prio[k] = mirror_prio[k-1];
        end
        mirror_tags[pos] = tag;
        mirror_prio[pos] = prio;
        mirror_fill++;
        r.status = spq_pkg::ST_ENQUEUED;
      end
    end else if (mirror_fill == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.head_tag = mirror_tags[0];
      for (int k = 1; k < mirror_fill; k++) begin
        mirror_tags[k-1] = mirror_tags[k];
        mirror_prio[k-1] = mirror_prio[k];
      end
      mirror_fill--;
      r.status = spq_pkg::ST_DEQUEUED;
    end
    r.fill = COUNT_W'(mirror_fill);
    return r;
  endfunction

  function automatic void add_command(logic [OPW-1:0] op, logic [TAG_W-1:0] tag,
                                      logic [PRIO_W-1:0] prio);
    command_t c;
    c.op   = op;
    c.tag  = tag;
    c.prio = prio;
    command_backlog.push_back(c);
  endfunction

  // idle percentages by phase: sender-light, receiver-light, then none
  function automatic int send_idle_pct(int n);
    if (n < 600) return 16;
    if (n < 1200) return 58;
    return 0;
  endfunction

  function automatic int recv_idle_pct(int n);
    if (n < 600) return 58;
    if (n < 1200) return 16;
    return 0;
  endfunction

  // command driver
  always @(posedge clk) begin
    command_t nxt;
    logic     offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(serve_command(in_ch.op, in_ch.entry_tag,
                                                in_ch.entry_priority));
        n_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        offer = command_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct(n_sent);
        if (offer) begin
          nxt = command_backlog.pop_front();
          in_ch.op             <= nxt.op;
          in_ch.entry_tag      <= nxt.tag;
          in_ch.entry_priority <= nxt.prio;
        end
        in_ch.valid <= offer;
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: status %0d head_tag %0h fill_count %0d",
                 out_ch.status, out_ch.head_tag, out_ch.fill_count);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            errors++;
          end
          if (out_ch.head_tag !== want.head_tag) begin
            $error("head_tag: expected %0h, got %0h", want.head_tag, out_ch.head_tag);
            errors++;
          end
          if (out_ch.fill_count !== want.fill) begin
            $error("fill_count: expected %0d, got %0d", want.fill, out_ch.fill_count);
            errors++;
          end
        end
      end
      // long stall so the core holds a word and drops in_ch.ready
      if (hold_left == 0 && n_holds < 2 && n_results >= (n_holds + 1) * HOLD_SPACING) begin
        hold_left = HOLD_CYCLES;
        n_holds++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= $urandom_range(99) >= recv_idle_pct(n_results);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int                enq_pct;
    int                narrow;
    int                base;
    int                r;
    int                mix[4];
    logic [OPW-1:0]    op;
    logic [PRIO_W-1:0] prio;

    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.op             = spq_pkg::OP_ENQ;
    in_ch.entry_tag      = '0;
    in_ch.entry_priority = '0;
    out_ch.ready         = 1'b0;

    // directed: empty dequeue, alias clear, extremes, ties, full, dequeues, clear
    add_command(spq_pkg::OP_DEQ, '1, '1);
    add_command(OP_CLR_ALIAS, '1, '1);
    add_command(spq_pkg::OP_ENQ, '1, '1);
    add_command(spq_pkg::OP_ENQ, '0, '0);
    for (int i = 0; i < DEPTH_N - 2; i++)
      add_command(spq_pkg::OP_ENQ, TAG_W'(i + 1), PRIO_W'(8'h7f + i % 3));
    add_command(spq_pkg::OP_ENQ, 16'h5a5a, '0);
    add_command(spq_pkg::OP_DEQ, '0, '0);
    add_command(spq_pkg::OP_DEQ, '0, '0);
    add_command(spq_pkg::OP_CLR, '0, '0);
    add_command(spq_pkg::OP_DEQ, '0, '0);

    // bursts with a varying enqueue share so the queue swings between empty and full
    mix = '{25, 50, 75, 95};
    for (int b = 0; b < RANDOM_BURSTS; b++) begin
      enq_pct = mix[$urandom_range(3)];
      narrow  = $urandom_range(1);
      base    = $urandom_range(1) ? $urandom_range(252) : 252;
      for (int i = 0; i < BURST_LEN; i++) begin
        r = $urandom_range(99);
        if (r < 3) op = $urandom_range(1) ? spq_pkg::OP_CLR : OP_CLR_ALIAS;
        else if (r < enq_pct) op = spq_pkg::OP_ENQ;
        else op = spq_pkg::OP_DEQ;
        prio = narrow ? PRIO_W'(base + $urandom_range(3)) : PRIO_W'($urandom_range(255));
        add_command(op, TAG_W'($urandom), prio);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (command_backlog.size() != 0 || in_ch.valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
